[rtl/zero_one_knapsack_max_value_macros.svh]
// Assertion macros shared by the knapsack RTL.
`ifndef ZERO_ONE_KNAPSACK_MAX_VALUE_MACROS_SVH
`define ZERO_ONE_KNAPSACK_MAX_VALUE_MACROS_SVH

// Check cons in the same cycle as ante.
`define KNAP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("knapsack assertion failed");

// Check cons in the cycle after ante.
`define KNAP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("knapsack assertion failed");

`endif

[rtl/knap_pkg.sv]
// Shared constants and control/status types for the knapsack block.
package knap_pkg;

    localparam int MAX_CAPACITY_DEF = 1023;
    localparam int SUM_WIDTH_DEF    = 32;

    localparam int WEIGHT_WIDTH = 10;
    localparam int VALUE_WIDTH  = 16;
    localparam int CAP_WIDTH    = 10;
    localparam int OUT_WIDTH    = 32;
    localparam int IN_DATA_WIDTH = 32;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_end;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/knap_ram.sv]
// Generic RAM: one write port, two registered read ports.
module knap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[rtl/knap_ctrl.sv]
// Controller state machine sequencing accept, table sweep, drain and result beat.
`include "zero_one_knapsack_max_value_macros.svh"

module knap_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  knap_pkg::dp_status_t  status,
    output knap_pkg::ctrl_cmd_t   cmd
);

    import knap_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.start = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.step = 1'b1;
                if (status.sweep_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.finish = 1'b1;
                state_next = status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `KNAP_ASSERT_NEXT(a_accept_sweeps, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_SWEEP)

endmodule

[rtl/knap_dp.sv]
// Datapath: capacity register, table RAM, sweep counter, max/add stage and result beat.
`include "zero_one_knapsack_max_value_macros.svh"

module knap_dp #(
    parameter int MAX_CAPACITY = knap_pkg::MAX_CAPACITY_DEF,
    parameter int SUM_WIDTH    = knap_pkg::SUM_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [knap_pkg::CAP_WIDTH-1:0]       cfg_wdata,
    input  logic [knap_pkg::WEIGHT_WIDTH-1:0]    item_weight,
    input  logic [knap_pkg::VALUE_WIDTH-1:0]     item_value,
    input  logic                                 last_item,
    input  knap_pkg::ctrl_cmd_t                  cmd,
    output knap_pkg::dp_status_t                 status,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [knap_pkg::OUT_WIDTH-1:0]       m_tdata
);

    import knap_pkg::*;

    localparam int DEPTH = MAX_CAPACITY + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (AW > WEIGHT_WIDTH) ? AW : WEIGHT_WIDTH;
    localparam logic [AW-1:0] TOP     = AW'(MAX_CAPACITY);
    localparam logic [CW-1:0] TOP_EXT = CW'(MAX_CAPACITY);

    logic [CAP_WIDTH-1:0]    capacity_reg;
    logic [WEIGHT_WIDTH-1:0] weight_reg;
    logic [VALUE_WIDTH-1:0]  value_reg;
    logic                    last_reg;
    logic                    fresh_reg;
    logic [AW-1:0]           c_reg;
    logic                    s1_valid_reg;
    logic [AW-1:0]           s1_addr_reg;
    logic                    s1_ok_reg;
    logic [OUT_WIDTH-1:0]    result_reg;
    logic [OUT_WIDTH-1:0]    result_next;
    logic                    m_tvalid_reg;
    logic [OUT_WIDTH-1:0]    m_tdata_reg;

    logic [CW-1:0]          c_ext;
    logic [CW-1:0]          w_ext;
    logic [CW-1:0]          diff;
    logic                   take_ok;
    logic [AW-1:0]          addr_b;
    logic [CW-1:0]          cap_ext;
    logic [AW-1:0]          cap_eff;
    logic [SUM_WIDTH-1:0]   rd_a;
    logic [SUM_WIDTH-1:0]   rd_b;
    logic [SUM_WIDTH-1:0]   old_eff;
    logic [SUM_WIDTH-1:0]   b_eff;
    logic [SUM_WIDTH:0]     sum_ext;
    logic [SUM_WIDTH-1:0]   take;
    logic [SUM_WIDTH-1:0]   new_val;

    // Stage 0: issue reads for capacity c and c - w.
    always_comb begin
        c_ext   = CW'(c_reg);
        w_ext   = CW'(weight_reg);
        take_ok = (w_ext <= c_ext);
        diff    = c_ext - w_ext;
        addr_b  = take_ok ? diff[AW-1:0] : '0;
        cap_ext = CW'(capacity_reg);
        cap_eff = (cap_ext > TOP_EXT) ? TOP : cap_ext[AW-1:0];
    end

    knap_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (s1_valid_reg),
        .wr_addr   (s1_addr_reg),
        .wr_data   (new_val),
        .rd_addr_a (c_reg),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // Stage 1: saturating add, max, write back. A fresh table reads as zero.
    always_comb begin
        old_eff = fresh_reg ? '0 : rd_a;
        b_eff   = fresh_reg ? '0 : rd_b;
        sum_ext = (SUM_WIDTH + 1)'(b_eff) + (SUM_WIDTH + 1)'(value_reg);
        take    = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
        if (s1_addr_reg == '0) begin
            new_val = '0;
        end else if (s1_ok_reg && (take > old_eff)) begin
            new_val = take;
        end else begin
            new_val = old_eff;
        end
    end

    generate
        if (SUM_WIDTH > OUT_WIDTH) begin : g_sat_out
            always_comb begin
                result_next = (|new_val[SUM_WIDTH-1:OUT_WIDTH]) ? '1 : new_val[OUT_WIDTH-1:0];
            end
        end else begin : g_ext_out
            always_comb begin
                result_next = OUT_WIDTH'(new_val);
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
            fresh_reg    <= 1'b1;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            c_reg        <= TOP;
        end else begin
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            if (cmd.start) begin
                c_reg <= TOP;
            end else if (cmd.step) begin
                c_reg <= c_reg - 1'b1;
            end
            s1_valid_reg <= cmd.step;
            if (cmd.finish) begin
                fresh_reg <= last_reg;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            weight_reg <= item_weight;
            value_reg  <= item_value;
            last_reg   <= last_item;
        end
        s1_addr_reg <= c_reg;
        s1_ok_reg   <= take_ok;
        if (s1_valid_reg && (s1_addr_reg == cap_eff)) begin
            result_reg <= result_next;
        end
        if (cmd.emit) begin
            m_tdata_reg <= result_reg;
        end
    end

    assign status.sweep_end = (c_reg == '0);
    assign status.last      = last_reg;
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid         = m_tvalid_reg;
    assign m_tdata          = m_tdata_reg;

    `KNAP_ASSERT_IMP(a_desc_addr, aclk, aresetn, s1_valid_reg && cmd.step, s1_addr_reg == c_reg + 1'b1)
    `KNAP_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit, !m_tvalid_reg || m_tready)
    `KNAP_ASSERT_NEXT(a_fresh_upd, aclk, aresetn, cmd.finish, fresh_reg == $past(last_reg))

endmodule

[rtl/zero_one_knapsack_max_value.sv]
// Top level of the 0/1 knapsack maximum value block: controller plus datapath.
// Each item sweeps the whole table once, one entry a cycle through the two-read-port RAM.
// s_tready falls on each accepted beat, back after SWEEP, DRAIN and, for a last item, EMIT.
// A last item's result beat is registered on leaving EMIT; a held beat stalls it in EMIT.
// Reset clears control and capacity and marks the table empty; no clearing pass is run.
// The table is marked empty again after every result, so no clearing pass is needed.
module zero_one_knapsack_max_value #(
    parameter int MAX_CAPACITY = knap_pkg::MAX_CAPACITY_DEF,
    parameter int SUM_WIDTH    = knap_pkg::SUM_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [knap_pkg::CAP_WIDTH-1:0]       cfg_wdata,     // capacity
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [knap_pkg::IN_DATA_WIDTH-1:0]   s_tdata,       // item_weight[9:0], item_value[25:10], zeros
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [knap_pkg::OUT_WIDTH-1:0]       m_tdata        // best_value[31:0]
);

    import knap_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    knap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    knap_dp #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_weight (s_tdata[WEIGHT_WIDTH-1:0]),
        .item_value  (s_tdata[WEIGHT_WIDTH+VALUE_WIDTH-1:WEIGHT_WIDTH]),
        .last_item   (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

[bench/testbench.sv]
// Self-checking bench for the knapsack block: streams item beats, predicts or looks up best values, compares.
`timescale 1ns / 1ps

module testbench;
    import knap_pkg::*;

    localparam int TABLE_DEPTH      = MAX_CAPACITY_DEF + 1;
    localparam int DRAIN_CYCLES     = MAX_CAPACITY_DEF + 16;
    localparam int CYCLE_LIMIT      = 4_000_000;
    localparam int PHASES           = 10;
    localparam int PHASE_ITEMS      = 43;
    localparam int CALM_ITEMS       = 60;
    localparam int LONG_HOLD_CYCLES = 6000;
    localparam int LONG_HOLD_AT     = 150;
    localparam int DIRECTED_COUNT   = 19;
    localparam int PAD_WIDTH        = IN_DATA_WIDTH - WEIGHT_WIDTH - VALUE_WIDTH;

    typedef struct packed {
        logic                   set_cap;
        logic [CAP_WIDTH-1:0]   cap;
        logic [WEIGHT_WIDTH-1:0] weight;
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
        logic                   known;
        logic [OUT_WIDTH-1:0]   best;
    } item_row_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CAP_WIDTH-1:0]     cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_WIDTH-1:0] s_tdata   = '0;
    logic                     s_tlast   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_WIDTH-1:0]     m_tdata;

    logic [OUT_WIDTH-1:0] value_table [TABLE_DEPTH] = '{default: '0};
    logic [CAP_WIDTH-1:0] capacity_now = '0;
    logic [OUT_WIDTH-1:0] best_value_due [$];

    int  mismatches  = 0;
    int  beats_in    = 0;
    int  cycle_count = 0;
    int  ready_gap   = 0;
    logic calm       = 1'b0;
    logic long_hold  = 1'b0;

    item_row_t directed_rows [DIRECTED_COUNT] = '{
        '{1'b0, 10'd0,    10'd0,    16'hFFFF, 1'b1, 1'b1, 32'd0},
        '{1'b1, 10'd1023, 10'd1023, 16'hFFFF, 1'b1, 1'b1, 32'd65535},
        '{1'b0, 10'd0,    10'd0,    16'd100,  1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd0,    16'd200,  1'b1, 1'b1, 32'd300},
        '{1'b0, 10'd0,    10'd1023, 16'd0,    1'b1, 1'b1, 32'd0},
        '{1'b1, 10'd5,    10'd6,    16'd1000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd1023, 16'hFFFF, 1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd5,    16'd7,    1'b1, 1'b1, 32'd7},
        '{1'b0, 10'd0,    10'd2,    16'd3,    1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd3,    16'd4,    1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd4,    16'd5,    1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd5,    16'd6,    1'b1, 1'b0, 32'd0},
        '{1'b1, 10'd1023, 10'd1,    16'd10,   1'b0, 1'b0, 32'd0},
        '{1'b1, 10'd1,    10'd1,    16'd20,   1'b1, 1'b1, 32'd20},
        '{1'b1, 10'd1023, 10'd512,  16'd40000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd511,  16'd30000, 1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd1,    16'd1,    1'b1, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd341,  16'h5555, 1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd682,  16'hAAAA, 1'b1, 1'b0, 32'd0}
    };

    logic [CAP_WIDTH-1:0] phase_caps [PHASES] = '{
        10'd1023, 10'd0, 10'd1, 10'd2, 10'd31, 10'd256, 10'd700, 10'd1023, 10'd0, 10'd0
    };

    zero_one_knapsack_max_value dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // item_weight[9:0], item_value[25:10], zeros
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // best_value[31:0]
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [OUT_WIDTH-1:0] absorb_item(input logic [WEIGHT_WIDTH-1:0] weight,
                                                         input logic [VALUE_WIDTH-1:0] value,
                                                         input logic last);
        logic [OUT_WIDTH:0]   take;
        logic [OUT_WIDTH-1:0] best;
        best = '0;
        for (int c = TABLE_DEPTH - 1; c >= 1; c--) begin
            if (int'(weight) <= c) begin
                take = {1'b0, value_table[c - int'(weight)]} + (OUT_WIDTH + 1)'(value);
                if (take[OUT_WIDTH]) take[OUT_WIDTH-1:0] = '1;
                if (take[OUT_WIDTH-1:0] > value_table[c]) value_table[c] = take[OUT_WIDTH-1:0];
            end
        end
        value_table[0] = '0;
        if (last) begin
            best = value_table[capacity_now];
            value_table = '{default: '0};
        end
        return best;
    endfunction

    task automatic note_mismatch(input string what, input logic [OUT_WIDTH-1:0] due,
                                 input logic [OUT_WIDTH-1:0] seen);
        if (mismatches < 10)
            $display("best_value %s: expected %0d, got %0d", what, due, seen);
        mismatches++;
    endtask

    task automatic send_item(input logic [WEIGHT_WIDTH-1:0] weight,
                             input logic [VALUE_WIDTH-1:0] value,
                             input logic last, input logic known,
                             input logic [OUT_WIDTH-1:0] best);
        logic [OUT_WIDTH-1:0] predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_WIDTH{1'b0}}, value, weight};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_in++;
        predicted = absorb_item(weight, value, last);
        if (last) best_value_due.push_back(known ? best : predicted);
    endtask

    task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
        s_tvalid <= 1'b0;
        while (best_value_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        capacity_now = cap;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            ready_gap <= 0;
        end else if (long_hold) begin
            m_tready <= 1'b0;
        end else if (ready_gap != 0) begin
            m_tready  <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready  <= 1'b0;
            ready_gap <= $urandom_range(0, 9);
        end else
            m_tready <= 1'b1;
    end

    // hold off the result side long enough for the input to stall
    initial begin
        wait (beats_in >= LONG_HOLD_AT);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    always @(posedge aclk) begin : result_check
        logic [OUT_WIDTH-1:0] due;
        if (aresetn && m_tvalid && m_tready) begin
            if (best_value_due.size() == 0) begin
                note_mismatch("without a pending item", 'x, m_tdata);
            end else begin
                due = best_value_due.pop_front();
                if (m_tdata !== due) note_mismatch("mismatch", due, m_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[zero_one_knapsack_max_value] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CAP_WIDTH-1:0]    cap;
        logic [WEIGHT_WIDTH-1:0] weight;
        logic [VALUE_WIDTH-1:0]  value;
        logic                    last;
        int                      reach;
        int                      sent;
        sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_cap) write_capacity(directed_rows[i].cap);
            send_item(directed_rows[i].weight, directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].known, directed_rows[i].best);
        end
        for (int p = 0; p < PHASES; p++) begin
            cap = (p >= 8) ? CAP_WIDTH'($urandom_range(0, 1023)) : phase_caps[p];
            write_capacity(cap);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (sent >= PHASES * PHASE_ITEMS - CALM_ITEMS) calm <= 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    weight = WEIGHT_WIDTH'($urandom_range(0, 1023));
                end else begin
                    reach  = (cap == 0) ? 3 : ($urandom_range(0, 1) ? int'(cap) : int'(cap) / 4);
                    weight = WEIGHT_WIDTH'($urandom_range(0, reach));
                end
                case ($urandom_range(0, 9))
                    0: value = '0;
                    1: value = '1;
                    default: value = VALUE_WIDTH'($urandom_range(0, 65535));
                endcase
                last = long_hold || ($urandom_range(0, 3) == 0);
                send_item(weight, value, last, 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        while (best_value_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("[zero_one_knapsack_max_value] OK");
        else
            $display("[zero_one_knapsack_max_value] ERROR");
        $finish;
    end

endmodule
